// ===== src/bpd_pkg.sv =====
package bpd_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int SUM_W   = ADDR_W + 1;
    localparam int SYM_W   = 8;
    localparam int DIST_W  = 11;

    localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;

    typedef struct packed {
        logic [SYM_W-1:0] sym_a;
        logic [SYM_W-1:0] sym_b;
        logic             last;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              unbalanced_a;
        logic              unbalanced_b;
        logic              too_long;
    } t_out_word;

    // per-structure status of the word being accepted
    typedef struct packed {
        logic              pop;
        logic              under;
        logic              open_left;
        logic [ADDR_W-1:0] pairs;
    } t_stk_stat;

    // what the compare stage needs from the accept stage
    typedef struct packed {
        logic              last;
        logic              pop_a;
        logic              pop_b;
        logic [ADDR_W-1:0] pairs_a;
        logic [ADDR_W-1:0] pairs_b;
        logic              unbal_a;
        logic              unbal_b;
        logic              too_long;
    } t_s0;

endpackage

// ===== src/bpd_ram.sv =====
module bpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/bpd_stack.sv =====
module bpd_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_clear,
    input  logic [bpd_pkg::SYM_W-1:0]     i_sym,
    input  logic [bpd_pkg::ADDR_W-1:0]    i_pos,
    output bpd_pkg::t_stk_stat            o_stat,
    output logic [bpd_pkg::ADDR_W-1:0]    o_opener
);

    logic [bpd_pkg::POS_W-1:0]  r_depth, n_depth, depth_next;
    logic [bpd_pkg::ADDR_W-1:0] r_pairs, n_pairs, pairs_next;
    logic                       is_open, is_close, push, pop, under;
    logic [bpd_pkg::POS_W-1:0]  depth_dec;

    assign is_open   = i_take && (i_sym == bpd_pkg::SYM_OPEN);
    assign is_close  = i_take && (i_sym == bpd_pkg::SYM_CLOSE);
    assign push      = is_open && (r_depth < bpd_pkg::POS_W'(bpd_pkg::MAX_LEN));
    assign pop       = is_close && (r_depth != '0);
    assign under     = is_close && (r_depth == '0);
    assign depth_dec = r_depth - bpd_pkg::POS_W'(1);

    always_comb begin
        depth_next = r_depth;
        if (push) begin
            depth_next = r_depth + bpd_pkg::POS_W'(1);
        end else if (pop) begin
            depth_next = depth_dec;
        end
        pairs_next = r_pairs + bpd_pkg::ADDR_W'(pop);
        n_depth    = i_clear ? '0 : depth_next;
        n_pairs    = i_clear ? '0 : pairs_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_pairs <= '0;
        end else begin
            r_depth <= n_depth;
            r_pairs <= n_pairs;
        end
    end

    // push writes at the top, pop reads just below it; a pop right after a
    // push reads the entry that push already wrote to the RAM, so no bypass is needed
    bpd_ram #(
        .WIDTH (bpd_pkg::ADDR_W),
        .DEPTH (bpd_pkg::MAX_LEN)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (r_depth[bpd_pkg::ADDR_W-1:0]),
        .i_wr_data (i_pos),
        .i_rd_en   (pop),
        .i_rd_addr (depth_dec[bpd_pkg::ADDR_W-1:0]),
        .o_rd_data (o_opener)
    );

    assign o_stat.pop       = pop;
    assign o_stat.under     = under;
    assign o_stat.open_left = (depth_next != '0);
    assign o_stat.pairs     = pairs_next;

endmodule

// ===== src/bpd_result.sv =====
module bpd_result (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  bpd_pkg::t_s0               i_s0,
    input  logic [bpd_pkg::ADDR_W-1:0] i_opener_a,
    input  logic [bpd_pkg::ADDR_W-1:0] i_opener_b,
    output logic                       o_stall,
    output logic                       o_valid,
    input  logic                       i_ready,
    output bpd_pkg::t_out_word         o_data
);

    logic                       r_s1_valid;
    bpd_pkg::t_s0               r_s1;
    logic [bpd_pkg::ADDR_W-1:0] r_common;
    logic                       r_out_valid;
    bpd_pkg::t_out_word         r_out;

    logic                       match, advance;
    logic [bpd_pkg::ADDR_W-1:0] common_tot;
    logic [bpd_pkg::SUM_W-1:0]  dist_sum;

    // a finished last word may only wait here while the output word is held
    assign o_stall    = r_s1_valid && r_s1.last && r_out_valid && !i_ready;
    assign advance    = r_s1_valid && !o_stall;
    assign match      = r_s1.pop_a && r_s1.pop_b && (i_opener_a == i_opener_b);
    assign common_tot = r_common + bpd_pkg::ADDR_W'(match);
    assign dist_sum   = bpd_pkg::SUM_W'(r_s1.pairs_a) + bpd_pkg::SUM_W'(r_s1.pairs_b)
                      - {common_tot, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_common    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_acc;
            end
            if (advance) begin
                r_common <= r_s1.last ? '0 : common_tot;
            end
            if (advance && r_s1.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1 <= i_s0;
        end
        if (advance && r_s1.last) begin
            r_out.distance     <= bpd_pkg::DIST_W'(dist_sum);
            r_out.unbalanced_a <= r_s1.unbal_a;
            r_out.unbalanced_b <= r_s1.unbal_b;
            r_out.too_long     <= r_s1.too_long;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== src/dot_bracket_pair_distance.sv =====
// Base pair distance of two dot-bracket structures. One word per cycle carries
// a character of each structure; the word marked last produces one result word
// (distance plus error flags) from the output register and clears the stacks,
// so the next pair may follow directly. Sustained rate is one word per clock
// unless a held output stalls the input: each structure's opener stack sits in
// its own MAX_LEN x log2(MAX_LEN) RAM that does one push or one pop per cycle,
// and the opener compare for common pairs runs one stage later on the registered
// read data. Input ready drops only while a finished result waits behind a held
// output word. Stack RAMs need no clearing: depth counters reset to zero.
module dot_bracket_pair_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bpd_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bpd_pkg::t_out_word o_data
);

    logic [bpd_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                       r_unbal_a, r_unbal_b, r_too_long;
    logic                       n_unbal_a, n_unbal_b, n_too_long;
    logic                       acc, take, clear, full, stall;
    bpd_pkg::t_stk_stat         stat_a, stat_b;
    logic [bpd_pkg::ADDR_W-1:0] opener_a, opener_b;
    bpd_pkg::t_s0               s0;

    assign o_ready = !stall;
    assign acc     = i_valid && o_ready;
    assign full    = (r_pos == bpd_pkg::POS_W'(bpd_pkg::MAX_LEN));
    assign take    = acc && !full;
    assign clear   = acc && i_data.last;

    bpd_stack u_stack_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_clear  (clear),
        .i_sym    (i_data.sym_a),
        .i_pos    (r_pos[bpd_pkg::ADDR_W-1:0]),
        .o_stat   (stat_a),
        .o_opener (opener_a)
    );

    bpd_stack u_stack_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_clear  (clear),
        .i_sym    (i_data.sym_b),
        .i_pos    (r_pos[bpd_pkg::ADDR_W-1:0]),
        .o_stat   (stat_b),
        .o_opener (opener_b)
    );

    // flags as they stand once this word is applied
    always_comb begin
        n_unbal_a  = r_unbal_a || stat_a.under || (i_data.last && stat_a.open_left);
        n_unbal_b  = r_unbal_b || stat_b.under || (i_data.last && stat_b.open_left);
        n_too_long = r_too_long || full;
        n_pos      = take ? r_pos + bpd_pkg::POS_W'(1) : r_pos;

        s0.last     = i_data.last;
        s0.pop_a    = stat_a.pop;
        s0.pop_b    = stat_b.pop;
        s0.pairs_a  = stat_a.pairs;
        s0.pairs_b  = stat_b.pairs;
        s0.unbal_a  = n_unbal_a;
        s0.unbal_b  = n_unbal_b;
        s0.too_long = n_too_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_unbal_a  <= 1'b0;
            r_unbal_b  <= 1'b0;
            r_too_long <= 1'b0;
        end else if (acc) begin
            r_pos      <= i_data.last ? '0 : n_pos;
            r_unbal_a  <= n_unbal_a && !i_data.last;
            r_unbal_b  <= n_unbal_b && !i_data.last;
            r_too_long <= n_too_long && !i_data.last;
        end
    end

    bpd_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_s0       (s0),
        .i_opener_a (opener_a),
        .i_opener_b (opener_b),
        .o_stall    (stall),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

// ===== src/bpd_checker.sv =====
module bpd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input bpd_pkg::t_in_word  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input bpd_pkg::t_out_word o_data
);

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word dropped or changed while stalled");

    // input side backs off only behind a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a held result");

    // a fresh result comes from an accepted last input word
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_data.last, 2))
        else $error("result word without a last input word");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.distance <= bpd_pkg::DIST_W'(bpd_pkg::MAX_LEN))
        else $error("distance out of range");

endmodule

bind dot_bracket_pair_distance bpd_checker u_bpd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
